>>> rtl/mexp_pkg.sv
// Package for the modular exponentiation core: constants, controller states and command types.
`timescale 1ns / 1ps

package mexp_pkg;

  // Width of every field on the channels.
  localparam int FIELD_BITS = 32;

  // Default datapath width.
  localparam int DEFAULT_WORD_BITS = 32;

  // Modulus held after reset.
  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = 32'd364875103;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_BIT,
    ST_MUL_RS,
    ST_MUL_SS,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take a new word, set up the base reduction
    logic red_step;  // one step of the base reduction
    logic red_last;  // last reduction step, its result becomes the square
    logic mul_step;  // one shift-and-add step of a modular product
    logic wr_res;    // product done, it becomes the running result
    logic wr_sq;     // product done, it becomes the new square
    logic start_rs;  // set up the product result times square
    logic start_ss;  // set up the product square times square
    logic exp_shift; // move on to the next exponent bit
    logic emit;      // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_small; // modulus below two
    logic exp_bit;   // current exponent bit
    logic exp_zero;  // no set exponent bits remain
    logic out_stall; // output register full and not being taken
  } status_t;

endpackage

>>> rtl/mexp_if.sv
// Channel interfaces of the modular exponentiation core.
`timescale 1ns / 1ps

interface mexp_in_if;
  import mexp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] base;
  logic [FIELD_BITS-1:0] exponent;
  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] power_result;
  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);
endinterface

interface mexp_cfg_if;
  import mexp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mexp_datapath.sv
// Datapath of the modular exponentiation core: residues, shift-and-add unit, output register.
`timescale 1ns / 1ps

module mexp_datapath import mexp_pkg::*; #(
  parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [WORD_BITS-1:0] mod_w,
  input  logic [WORD_BITS-1:0] base_w,
  input  logic [WORD_BITS-1:0] exp_w,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [WORD_BITS-1:0] out_word
);

  logic [WORD_BITS-1:0] res;
  logic [WORD_BITS-1:0] sq;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] addend;
  logic [WORD_BITS-1:0] mulb;
  logic [WORD_BITS-1:0] expo;

  logic [WORD_BITS:0]   mod_x;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS:0]   rem;
  logic [WORD_BITS-1:0] acc_mul_next;
  logic [WORD_BITS-1:0] addend_next;
  logic [WORD_BITS-1:0] acc_red_next;
  logic                 mod_small;

  assign mod_x     = {1'b0, mod_w};
  assign mod_small = (mod_w[WORD_BITS-1:1] == '0);

  // Shift-and-add step: both sums stay below twice the modulus, so one
  // conditional subtraction brings each back into range.
  always_comb begin
    sum = {1'b0, acc} + {1'b0, addend};
    if (sum >= mod_x) begin
      sum = sum - mod_x;
    end
    acc_mul_next = mulb[0] ? sum[WORD_BITS-1:0] : acc;
    dbl = {addend, 1'b0};
    if (dbl >= mod_x) begin
      dbl = dbl - mod_x;
    end
    addend_next = dbl[WORD_BITS-1:0];
  end

  // Restoring reduction of the base, one base bit per step from the top.
  always_comb begin
    rem = {acc, mulb[WORD_BITS-1]};
    if (rem >= mod_x) begin
      rem = rem - mod_x;
    end
    acc_red_next = rem[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res  <= mod_small ? '0 : {{(WORD_BITS-1){1'b0}}, 1'b1};
      acc  <= '0;
      mulb <= base_w;
      expo <= exp_w;
    end
    if (cmd.red_step) begin
      acc  <= acc_red_next;
      mulb <= {mulb[WORD_BITS-2:0], 1'b0};
    end
    if (cmd.red_last) begin
      sq <= acc_red_next;
    end
    if (cmd.mul_step) begin
      acc    <= acc_mul_next;
      addend <= addend_next;
      mulb   <= {1'b0, mulb[WORD_BITS-1:1]};
    end
    if (cmd.wr_res) begin
      res <= acc_mul_next;
    end
    if (cmd.wr_sq) begin
      sq <= acc_mul_next;
    end
    if (cmd.exp_shift) begin
      expo <= {1'b0, expo[WORD_BITS-1:1]};
    end
    if (cmd.start_rs) begin
      acc    <= '0;
      addend <= res;
      mulb   <= sq;
    end else if (cmd.start_ss) begin
      acc    <= '0;
      addend <= sq;
      mulb   <= sq;
    end
    if (cmd.emit) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.mod_small = mod_small;
  assign status.exp_bit   = expo[0];
  assign status.exp_zero  = (expo == '0);
  assign status.out_stall = out_valid && !out_ready;

endmodule

>>> rtl/mexp_controller.sv
// Controller of the modular exponentiation core: sequencing state machine and step counter.
`timescale 1ns / 1ps

module mexp_controller import mexp_pkg::*; #(
  parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int CNT_W = $clog2(WORD_BITS);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             count_last;

  assign count_last = (count == CNT_W'(WORD_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Step counter runs only inside the reduction and the products.
  always_comb begin
    unique case (state)
      ST_REDUCE, ST_MUL_RS, ST_MUL_SS: count_next = count_last ? '0 : count + 1'b1;
      default:                         count_next = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.mod_small ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (count_last) begin
          state_next = ST_BIT;
        end
      end
      ST_BIT: begin
        priority if (status.exp_zero) begin
          state_next = ST_DONE;
        end else if (status.exp_bit) begin
          state_next = ST_MUL_RS;
        end else begin
          state_next = ST_MUL_SS;
        end
      end
      ST_MUL_RS: begin
        if (count_last) begin
          state_next = ST_MUL_SS;
        end
      end
      ST_MUL_SS: begin
        if (count_last) begin
          state_next = ST_BIT;
        end
      end
      ST_DONE: begin
        if (!status.out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
        cmd.red_last = count_last;
      end
      ST_BIT: begin
        if (!status.exp_zero) begin
          cmd.start_rs = status.exp_bit;
          cmd.start_ss = !status.exp_bit;
        end
      end
      ST_MUL_RS: begin
        cmd.mul_step = 1'b1;
        cmd.wr_res   = count_last;
        cmd.start_ss = count_last;
      end
      ST_MUL_SS: begin
        cmd.mul_step  = 1'b1;
        cmd.wr_sq     = count_last;
        cmd.exp_shift = count_last;
      end
      ST_DONE: begin
        cmd.emit = !status.out_stall;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/modular_exponentiation_core.sv
// Top level of the modular exponentiation core: channels, modulus register, checks.
`timescale 1ns / 1ps

// Computes base to the power exponent modulo the configured modulus, by
// right-to-left square-and-multiply with shift-and-add modular products.
// Channels: operands carries one word of base and exponent, result carries
// one word of power_result for each operand word, in order. modulus_cfg
// writes the modulus; it is always ready and must only be used while the
// core is idle with no result outstanding.
// Sequence: the word is taken and the base is reduced, then for each
// exponent bit up to the highest set one there is a decision state, a
// multiply when the bit is set and a squaring; a last decision ends the
// loop and the output register is loaded. A modulus below two skips all
// work and gives zero.
// The time is set by the single shift-and-add unit, one multiplier bit a cycle.
// One word is worked on at a time; operands is ready only while the
// controller is idle. The result sits in an output register, so a stalled
// receiver does not stop the next operand word from being taken, but that
// word finishes only once the register is free again.
// Synchronous reset empties the output register, returns the controller to
// idle and sets the modulus to its reset value.

module modular_exponentiation_core import mexp_pkg::*; #(
  parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
  input logic        clk,
  input logic        rst,
  mexp_in_if.sink    operands,
  mexp_out_if.source result,
  mexp_cfg_if.sink   modulus_cfg
);

  localparam int EXT_BITS = WORD_BITS + FIELD_BITS;

  logic [FIELD_BITS-1:0] modulus;
  logic [EXT_BITS-1:0]   mod_ext;
  logic [EXT_BITS-1:0]   base_ext;
  logic [EXT_BITS-1:0]   exp_ext;
  logic [EXT_BITS-1:0]   res_ext;
  logic [WORD_BITS-1:0]  mod_w;
  logic [WORD_BITS-1:0]  res_w;
  cmd_t                  cmd;
  status_t               status;

  // The modulus register takes a write whenever one is offered.
  assign modulus_cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (modulus_cfg.valid) begin
      modulus <= modulus_cfg.data;
    end
  end

  // Fields are cut or zero-extended to the datapath width.
  assign mod_ext  = {{WORD_BITS{1'b0}}, modulus};
  assign base_ext = {{WORD_BITS{1'b0}}, operands.base};
  assign exp_ext  = {{WORD_BITS{1'b0}}, operands.exponent};
  assign mod_w    = mod_ext[WORD_BITS-1:0];
  assign res_ext  = {{FIELD_BITS{1'b0}}, res_w};
  assign result.power_result = res_ext[FIELD_BITS-1:0];

  mexp_controller #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (operands.valid),
    .in_ready (operands.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mexp_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .mod_w     (mod_w),
    .base_w    (base_ext[WORD_BITS-1:0]),
    .exp_w     (exp_ext[WORD_BITS-1:0]),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_word  (res_w)
  );

  // Once a word is taken the core is busy with it and not ready in the cycle after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    operands.valid && operands.ready |=> !operands.ready)
    else $error("operand taken while the previous one is still in work");

  // Every result is a residue of the current modulus when the modulus is at least two.
  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && (mod_w >= WORD_BITS'(2)) |-> (res_w < mod_w))
    else $error("result not reduced below the modulus");

  // A modulus below two always gives zero.
  a_small_modulus: assert property (@(posedge clk) disable iff (rst)
    result.valid && (mod_w < WORD_BITS'(2)) |-> (res_w == '0))
    else $error("nonzero result for a modulus below two");

endmodule
